FILE: design/nsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the netstring request parser.
// No dependencies; imported by netstring_request_parser.
package nsp_pkg;

    // Parser phases. Codes above PH_STOPPED mean nothing and fall to the stopped phase.
    typedef enum logic [3:0] {
        PH_OUTER     = 4'd0,
        PH_MSGLEN    = 4'd1,
        PH_MSGBODY   = 4'd2,
        PH_MSGCOMMA  = 4'd3,
        PH_ADDRLEN   = 4'd4,
        PH_ADDRBODY  = 4'd5,
        PH_ADDRCOMMA = 4'd6,
        PH_FINAL     = 4'd7,
        PH_STOPPED   = 4'd8
    } t_phase;

    // Result kinds.
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_MSG    = 3'd1,
        K_SENDER = 3'd2,
        K_RCPT   = 3'd3,
        K_AEND   = 3'd4,
        K_DONE   = 3'd5,
        K_PERR   = 3'd6,
        K_RERR   = 3'd7
    } t_kind;

    // Configuration register indexes (word address).
    typedef enum logic [1:0] {
        REG_HEADER_BUDGET = 2'd0,
        REG_ADDR_LIMIT    = 2'd1,
        REG_LENGTH_LIMIT  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       addr_ok;
        logic       accepted;
    } t_result;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] HEADER_BUDGET_RST = 16'd100;
    localparam logic [15:0] ADDR_LIMIT_RST    = 16'd1000;
    localparam logic [31:0] LENGTH_LIMIT_RST  = 32'd200000000;

    localparam logic [7:0] ASCII_COLON = 8'd58;
    localparam logic [7:0] ASCII_COMMA = 8'd44;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;

endpackage

FILE: design/netstring_request_parser.sv
`timescale 1ns / 1ps
// Latency: a result is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register accepts a new byte whenever it
// is empty or its result is taken in the same cycle.
// Reset (synchronous, active low) restores the registers to their defaults, the budget to
// the header budget, and the parser to the outer length; the output register empties.
// Byte-serial parser for nested netstring mail-queue requests; uses nsp_pkg.
module netstring_request_parser
    import nsp_pkg::*;
#(
    parameter int LEN_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_data,
    output logic                  o_addr_ok,
    output logic                  o_accepted,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [15:0]          r_header_budget;
    logic [15:0]          r_addr_limit;
    logic [31:0]          r_length_limit;

    t_phase               r_phase, n_phase;
    logic [LEN_WIDTH-1:0] r_budget, n_budget;
    logic [LEN_WIDTH-1:0] r_length_acc, n_length_acc;
    logic [LEN_WIDTH-1:0] r_remaining, n_remaining;
    logic                 r_is_sender, n_is_sender;
    logic                 r_oversize, n_oversize;
    logic                 r_saw_zero, n_saw_zero;
    logic                 r_all_ok, n_all_ok;

    logic                 r_out_valid;
    t_result              r_out, n_out;

    logic                 w_in_fire;
    logic                 w_cfg_wr;
    t_reg_idx             w_reg_idx;
    logic [LEN_WIDTH-1:0] w_bud;
    logic                 w_bud_zero;
    logic [LEN_WIDTH-1:0] w_bud_dec;
    logic [LEN_WIDTH-1:0] w_rem_dec;
    logic [LEN_WIDTH-1:0] w_acc_next;
    logic                 w_is_colon;
    logic                 w_is_comma;
    logic                 w_len_err;
    logic                 w_acc_zero;
    logic                 w_addr_good;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1:2] == 2'(REG_HEADER_BUDGET)) begin
            prdata = APB_DATA_W'(r_header_budget);
        end else if (paddr[APB_ADDR_W-1:2] == 2'(REG_ADDR_LIMIT)) begin
            prdata = APB_DATA_W'(r_addr_limit);
        end else if (paddr[APB_ADDR_W-1:2] == 2'(REG_LENGTH_LIMIT)) begin
            prdata = APB_DATA_W'(r_length_limit);
        end
    end

    // The closing comma always costs exactly one unit of budget.
    assign w_bud       = (r_phase == PH_FINAL) ? LEN_WIDTH'(1) : r_budget;
    assign w_bud_zero  = (w_bud == '0);
    assign w_bud_dec   = w_bud - LEN_WIDTH'(1);
    assign w_rem_dec   = r_remaining - LEN_WIDTH'(1);
    assign w_acc_next  = (r_length_acc << 3) + (r_length_acc << 1)
                       + LEN_WIDTH'(i_in_byte) - LEN_WIDTH'(ASCII_ZERO);
    assign w_is_colon  = (i_in_byte == ASCII_COLON);
    assign w_is_comma  = (i_in_byte == ASCII_COMMA);
    assign w_len_err   = (r_length_acc > LEN_WIDTH'(r_length_limit));
    assign w_acc_zero  = (r_length_acc == '0);
    assign w_addr_good = !r_oversize && !r_saw_zero;

    // Next state of the parser and its counters.
    always_comb begin
        n_phase      = r_phase;
        n_budget     = r_budget;
        n_length_acc = r_length_acc;
        n_remaining  = r_remaining;
        n_is_sender  = r_is_sender;
        n_oversize   = r_oversize;
        n_saw_zero   = r_saw_zero;
        n_all_ok     = r_all_ok;
        if (r_phase != PH_STOPPED) begin
            if (w_bud_zero) begin
                n_phase = PH_STOPPED;
            end else begin
                n_budget = w_bud_dec;
                case (r_phase)
                    PH_OUTER, PH_MSGLEN, PH_ADDRLEN: begin
                        if (w_is_colon) begin
                            n_length_acc = '0;
                            if (r_phase == PH_OUTER) begin
                                n_budget = r_length_acc;
                                n_phase  = PH_MSGLEN;
                            end else if (r_phase == PH_MSGLEN) begin
                                n_remaining = r_length_acc;
                                n_phase     = w_acc_zero ? PH_MSGCOMMA : PH_MSGBODY;
                            end else begin
                                n_remaining = r_length_acc;
                                n_oversize  = (r_length_acc >= LEN_WIDTH'(r_addr_limit));
                                n_saw_zero  = 1'b0;
                                n_phase     = w_acc_zero ? PH_ADDRCOMMA : PH_ADDRBODY;
                            end
                        end else if (w_len_err) begin
                            n_phase = PH_STOPPED;
                        end else begin
                            n_length_acc = w_acc_next;
                        end
                    end
                    PH_MSGBODY: begin
                        n_remaining = w_rem_dec;
                        if (w_rem_dec == '0) begin
                            n_phase = PH_MSGCOMMA;
                        end
                    end
                    PH_ADDRBODY: begin
                        n_remaining = w_rem_dec;
                        if (w_rem_dec == '0) begin
                            n_phase = PH_ADDRCOMMA;
                        end
                        if (!r_oversize && i_in_byte == 8'h00) begin
                            n_saw_zero = 1'b1;
                        end
                    end
                    PH_MSGCOMMA, PH_ADDRCOMMA, PH_FINAL: begin
                        if (!w_is_comma || r_phase == PH_FINAL) begin
                            n_phase = PH_STOPPED;
                        end else if (r_phase == PH_MSGCOMMA) begin
                            n_is_sender = 1'b1;
                            n_phase     = PH_ADDRLEN;
                        end else begin
                            n_all_ok    = r_all_ok && w_addr_good;
                            n_is_sender = 1'b0;
                            n_phase     = (w_bud_dec != '0) ? PH_ADDRLEN : PH_FINAL;
                        end
                    end
                    default: begin
                        n_phase = PH_STOPPED;
                    end
                endcase
            end
        end
    end

    // Result for the byte being accepted.
    always_comb begin
        n_out = '{kind: K_NONE, data: 8'h00, addr_ok: 1'b0, accepted: 1'b0};
        if (r_phase != PH_STOPPED) begin
            if (w_bud_zero) begin
                n_out.kind = K_PERR;
            end else begin
                case (r_phase)
                    PH_OUTER, PH_MSGLEN, PH_ADDRLEN: begin
                        if (!w_is_colon && w_len_err) begin
                            n_out.kind = K_RERR;
                        end
                    end
                    PH_MSGBODY: begin
                        n_out.kind = K_MSG;
                        n_out.data = i_in_byte;
                    end
                    PH_ADDRBODY: begin
                        if (!r_oversize) begin
                            n_out.kind = r_is_sender ? K_SENDER : K_RCPT;
                            n_out.data = i_in_byte;
                        end
                    end
                    PH_MSGCOMMA, PH_ADDRCOMMA, PH_FINAL: begin
                        if (!w_is_comma) begin
                            n_out.kind = K_PERR;
                        end else if (r_phase == PH_FINAL) begin
                            n_out.kind     = K_DONE;
                            n_out.accepted = r_all_ok;
                        end else if (r_phase == PH_ADDRCOMMA) begin
                            n_out.kind    = K_AEND;
                            n_out.addr_ok = w_addr_good;
                        end
                    end
                    default: begin
                        n_out.kind = K_NONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_budget <= HEADER_BUDGET_RST;
            r_addr_limit    <= ADDR_LIMIT_RST;
            r_length_limit  <= LENGTH_LIMIT_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_HEADER_BUDGET: r_header_budget <= pwdata[15:0];
                REG_ADDR_LIMIT:    r_addr_limit    <= pwdata[15:0];
                REG_LENGTH_LIMIT:  r_length_limit  <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OUTER;
            r_budget     <= LEN_WIDTH'(HEADER_BUDGET_RST);
            r_length_acc <= '0;
            r_remaining  <= '0;
            r_is_sender  <= 1'b1;
            r_oversize   <= 1'b0;
            r_saw_zero   <= 1'b0;
            r_all_ok     <= 1'b1;
        end else begin
            if (w_in_fire) begin
                r_phase      <= n_phase;
                r_length_acc <= n_length_acc;
                r_remaining  <= n_remaining;
                r_is_sender  <= n_is_sender;
                r_oversize   <= n_oversize;
                r_saw_zero   <= n_saw_zero;
                r_all_ok     <= n_all_ok;
            end
            // A new header budget also reloads the live budget before the outer colon.
            if (w_cfg_wr && w_reg_idx == REG_HEADER_BUDGET && r_phase == PH_OUTER) begin
                r_budget <= LEN_WIDTH'(pwdata[15:0]);
            end else if (w_in_fire) begin
                r_budget <= n_budget;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out.kind;
    assign o_data      = r_out.data;
    assign o_addr_ok   = r_out.addr_ok;
    assign o_accepted  = r_out.accepted;

`ifndef SYNTHESIS
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_STOPPED |=> r_phase == PH_STOPPED)
        else $error("parser left the stopped phase");

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && r_phase == PH_STOPPED |=> r_out.kind == K_NONE)
        else $error("byte after a terminal result produced a non-empty result");

    a_data_only_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != K_MSG && r_out.kind != K_SENDER
            && r_out.kind != K_RCPT |-> r_out.data == 8'h00)
        else $error("data set on a result that carries no byte");

    a_addr_ok_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.addr_ok |-> r_out.kind == K_AEND)
        else $error("addr_ok set outside an address end");
`endif

endmodule
